/* src/idt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package idt_pkg;

  localparam int NUM_SLOTS_DEF = 64;
  localparam int REQ_W         = 2;
  localparam int SLOT_ID_W     = 6;
  localparam int TIME_W        = 32;

  localparam logic [TIME_W-1:0] TIMEOUT_RST = 32'd20000;

  // request codes
  localparam logic [REQ_W-1:0] REQ_POLL   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ARM    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CANCEL = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;     // latch request item, reset scan trackers
    logic clr_wr;   // clearing pass: zero one table entry
    logic scan_rd;  // scan: read one table entry
    logic finish;   // build result, write table back
  } idt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cnt_last; // entry counter sits on the last slot
  } idt_stat_t;

endpackage

`default_nettype wire

/* src/idt_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module idt_ctrl (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire                out_ready,
  output idt_pkg::idt_cmd_t  cmd,
  input  idt_pkg::idt_stat_t stat
);
  import idt_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_LAT,
    ST_FIN
  } state_t;

  state_t state;

  assign in_ready    = (state == ST_IDLE);
  assign cmd.load    = in_valid && in_ready;
  assign cmd.clr_wr  = (state == ST_CLEAR);
  assign cmd.scan_rd = (state == ST_SCAN);
  assign cmd.finish  = (state == ST_FIN) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (stat.cnt_last) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd.load) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (stat.cnt_last) begin
            state <= ST_LAT;
          end
        end
        ST_LAT: begin
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (cmd.finish) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  // at most one datapath command per cycle
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.clr_wr, cmd.scan_rd, cmd.finish}))
    else $error("idt_ctrl: overlapping datapath commands");

  // a result never overwrites one not yet taken
  a_fin_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || out_ready))
    else $error("idt_ctrl: result register overwritten");

  // a new result only follows a finish step
  a_out_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.finish))
    else $error("idt_ctrl: result shown without finish");

  // no item taken while a scan or clearing pass runs
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan_rd || cmd.clr_wr) |-> !in_ready)
    else $error("idt_ctrl: item accepted while busy");

endmodule

`default_nettype wire

/* src/idt_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module idt_datapath #(
  parameter int NUM_SLOTS = idt_pkg::NUM_SLOTS_DEF
) (
  input  wire                                    clk,
  input  wire                                    rst,
  input  idt_pkg::idt_cmd_t                      cmd,
  output idt_pkg::idt_stat_t                     stat,
  input  wire  [idt_pkg::REQ_W-1:0]              req_type,
  input  wire  [idt_pkg::SLOT_ID_W-1:0]          slot_id,
  input  wire  [idt_pkg::TIME_W-1:0]             now_ms,
  input  wire                                    cfg_wr_en,
  input  wire  [idt_pkg::TIME_W-1:0]             cfg_wr_data,
  output logic                                   expired_valid,
  output logic [idt_pkg::SLOT_ID_W-1:0]          expired_slot,
  output logic                                   table_empty,
  output logic signed [idt_pkg::TIME_W-1:0]      ms_to_next
);
  import idt_pkg::*;

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int WIDE_W = SLOT_W + SLOT_ID_W;
  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

  // table word: {armed, deadline}
  logic [TIME_W:0] mem [NUM_SLOTS];

  // configuration and time
  logic [TIME_W-1:0] timeout;
  logic [TIME_W-1:0] cur_time;

  // latched request
  logic [REQ_W-1:0]  req_r;
  logic [SLOT_W-1:0] slot_r;
  logic              slot_ok;
  logic [TIME_W-1:0] new_dl;

  // entry counter and read stage
  logic [SLOT_W-1:0] cnt;
  logic [TIME_W:0]   rd_word;
  logic [SLOT_W-1:0] rd_idx;
  logic              rd_vld;

  // earliest and second earliest armed deadline
  logic              best_vld;
  logic [TIME_W-1:0] best_dl;
  logic [SLOT_W-1:0] best_idx;
  logic              sec_vld;
  logic [TIME_W-1:0] sec_dl;

  logic [WIDE_W-1:0] slot_wide;
  logic [WIDE_W-1:0] exp_wide;
  logic [TIME_W:0]   dl_sum;
  logic [TIME_W-1:0] dl_sat;
  logic              eff_armed;
  logic [TIME_W-1:0] eff_dl;
  logic              exp_hit;
  logic              st_vld;
  logic [TIME_W-1:0] st_dl;
  logic [TIME_W:0]   diff;
  logic [TIME_W-1:0] diff_sat;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  logic [TIME_W:0]   wr_word;

  assign stat.cnt_last = (cnt == LAST_IDX);

  assign slot_wide = {{SLOT_W{1'b0}}, slot_id};
  assign dl_sum    = {1'b0, cur_time} + {1'b0, timeout};
  assign dl_sat    = dl_sum[TIME_W] ? '1 : dl_sum[TIME_W-1:0];

  // the request's own slot is seen with its new state during the scan
  always_comb begin
    eff_armed = rd_word[TIME_W];
    eff_dl    = rd_word[TIME_W-1:0];
    if (slot_ok && (rd_idx == slot_r)) begin
      if (req_r == REQ_ARM) begin
        eff_armed = 1'b1;
        eff_dl    = new_dl;
      end else if (req_r == REQ_CANCEL) begin
        eff_armed = 1'b0;
      end
    end
  end

  // result: after an expiry the second earliest becomes the earliest
  always_comb begin
    exp_hit  = (req_r == REQ_POLL) && best_vld && (cur_time > best_dl);
    st_vld   = exp_hit ? sec_vld : best_vld;
    st_dl    = exp_hit ? sec_dl : best_dl;
    diff     = {1'b0, st_dl} - {1'b0, cur_time};
    diff_sat = (diff[TIME_W] != diff[TIME_W-1]) ?
               {diff[TIME_W], {(TIME_W-1){~diff[TIME_W]}}} : diff[TIME_W-1:0];
    exp_wide = {{SLOT_ID_W{1'b0}}, best_idx};
    wr_en    = 1'b0;
    wr_addr  = slot_r;
    wr_word  = {1'b1, new_dl};
    if (exp_hit) begin
      wr_en   = 1'b1;
      wr_addr = best_idx;
      wr_word = {1'b0, best_dl};
    end else if (slot_ok && (req_r == REQ_ARM)) begin
      wr_en   = 1'b1;
    end else if (slot_ok && (req_r == REQ_CANCEL)) begin
      wr_en   = 1'b1;
      wr_word = {1'b0, new_dl};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout  <= TIMEOUT_RST;
      cur_time <= '0;
      cnt      <= '0;
      rd_vld   <= 1'b0;
      best_vld <= 1'b0;
      sec_vld  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        timeout <= cfg_wr_data;
      end
      if (cmd.load && (req_type == REQ_POLL)) begin
        cur_time <= now_ms;
      end
      if (cmd.clr_wr || cmd.scan_rd) begin
        cnt <= stat.cnt_last ? '0 : cnt + 1'b1;
      end
      rd_vld <= cmd.scan_rd;
      if (cmd.load) begin
        best_vld <= 1'b0;
        sec_vld  <= 1'b0;
      end else if (rd_vld && eff_armed) begin
        if (!best_vld || (eff_dl < best_dl)) begin
          best_vld <= 1'b1;
          sec_vld  <= best_vld;
        end else if (!sec_vld || (eff_dl < sec_dl)) begin
          sec_vld  <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r   <= req_type;
      slot_r  <= slot_wide[SLOT_W-1:0];
      slot_ok <= (slot_wide < WIDE_W'(NUM_SLOTS));
      new_dl  <= dl_sat;
    end
    if (cmd.scan_rd) begin
      rd_idx <= cnt;
    end
    if (rd_vld && eff_armed) begin
      if (!best_vld || (eff_dl < best_dl)) begin
        best_dl  <= eff_dl;
        best_idx <= rd_idx;
        sec_dl   <= best_dl;
      end else if (!sec_vld || (eff_dl < sec_dl)) begin
        sec_dl <= eff_dl;
      end
    end
    if (cmd.finish) begin
      expired_valid <= exp_hit;
      expired_slot  <= exp_hit ? exp_wide[SLOT_ID_W-1:0] : '0;
      table_empty   <= !st_vld;
      ms_to_next    <= st_vld ? diff_sat : '1;
    end
  end

  // deadline table
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem[cnt] <= '0;
    end else if (cmd.finish && wr_en) begin
      mem[wr_addr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      rd_word <= mem[cnt];
    end
  end

endmodule

`default_nettype wire

/* src/idle_deadline_table_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Idle deadline table: one millisecond deadline per connection slot. A poll
// stores now_ms as the current time and expires the earliest armed slot when
// that time is strictly past its deadline; an arm sets (or refreshes) a
// slot's deadline to current time plus timeout_ms, saturating at all ones; a
// cancel disarms a slot. Each item gives exactly one result carrying the
// expiry, whether the table is empty and the saturated signed time to the
// earliest deadline (-1 when empty). Ties go to the lower slot. A result is
// shown after one sequential pass over the deadline RAM through its single
// read port, a read latency state and a finish state. The block then returns
// to idle, so no new item is taken while one is in flight; a result still
// held by out_ready low holds the next item's finish step. A poll's expiry
// and the new earliest deadline come out of that same pass. After reset a
// clearing pass over every slot runs before the first item is accepted;
// timeout_ms writes are taken at any time.
module idle_deadline_table_unit #(
  parameter int NUM_SLOTS = idt_pkg::NUM_SLOTS_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  // request channel
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire  [idt_pkg::REQ_W-1:0]         req_type,
  input  wire  [idt_pkg::SLOT_ID_W-1:0]     slot_id,
  input  wire  [idt_pkg::TIME_W-1:0]        now_ms,
  // result channel
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic                              expired_valid,
  output logic [idt_pkg::SLOT_ID_W-1:0]     expired_slot,
  output logic                              table_empty,
  output logic signed [idt_pkg::TIME_W-1:0] ms_to_next,
  // timeout_ms register
  input  wire                               cfg_wr_en,
  input  wire  [idt_pkg::TIME_W-1:0]        cfg_wr_data
);
  import idt_pkg::*;

  idt_cmd_t  cmd;
  idt_stat_t stat;

  // sequencing: clearing pass, scan, finish, result handshake
  idt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // deadline RAM, earliest-deadline tracking, result registers
  idt_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .req_type      (req_type),
    .slot_id       (slot_id),
    .now_ms        (now_ms),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .expired_valid (expired_valid),
    .expired_slot  (expired_slot),
    .table_empty   (table_empty),
    .ms_to_next    (ms_to_next)
  );

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

// Self-checking bench for the idle deadline table. A directed table of items
// is driven first (reset status, ties, strict expiry, deadline saturation,
// ms_to_next saturation at both ends, timeout of zero, unused request code),
// then six random phases, each under its own timeout_ms setting. Every
// accepted item runs through a local copy of the table to predict its single
// result; results are compared field by field in arrival order.
module testbench;
  import idt_pkg::*;

  localparam int             CLK_PERIOD  = 12;
  localparam int             RESET_CYCLES = 8;
  localparam int             NUM_SLOTS   = NUM_SLOTS_DEF;
  // Item time; the idle gaps and the tail wait use it.
  localparam int             ITEM_LATENCY = NUM_SLOTS + 3;
  localparam int             STALL_LIMIT = 2000;
  localparam int             PHASES      = 6;
  localparam int             PHASE_ITEMS = 210;
  localparam int             IDLE_PCT    = 34;
  // request code the block must treat as a no-op
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    logic                     expired;
    logic [SLOT_ID_W-1:0]     slot;
    logic                     empty;
    logic signed [TIME_W-1:0] ms_left;
  } result_t;

  typedef struct {
    bit                   is_cfg;
    logic [TIME_W-1:0]    cfg_value;
    logic [REQ_W-1:0]     req;
    logic [SLOT_ID_W-1:0] slot;
    logic [TIME_W-1:0]    now;
    bit                   typed;    // want holds a hand-written result
    result_t              want;
  } stim_row_t;

  // DUT signals
  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [REQ_W-1:0]         req_type = REQ_POLL;
  logic [SLOT_ID_W-1:0]     slot_id = '0;
  logic [TIME_W-1:0]        now_ms = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     expired_valid;
  logic [SLOT_ID_W-1:0]     expired_slot;
  logic                     table_empty;
  logic signed [TIME_W-1:0] ms_to_next;
  logic                     cfg_wr_en = 1'b0;
  logic [TIME_W-1:0]        cfg_wr_data = '0;

  // local copy of the table, updated at each acceptance
  logic [TIME_W-1:0] tbl_deadline [NUM_SLOTS];
  logic              tbl_armed    [NUM_SLOTS];
  logic [TIME_W-1:0] clock_ms        = '0;
  logic [TIME_W-1:0] timeout_setting = TIMEOUT_RST;

  result_t   pending_results [$];
  stim_row_t directed_rows   [$];
  int        fail_count   = 0;
  int        stall_cycles = 0;
  bit        no_idle      = 1'b0;   // both sides drop idling while set

  idle_deadline_table_unit #(
    .NUM_SLOTS(NUM_SLOTS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .slot_id      (slot_id),
    .now_ms       (now_ms),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .expired_valid(expired_valid),
    .expired_slot (expired_slot),
    .table_empty  (table_empty),
    .ms_to_next   (ms_to_next),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic result_t make_result(logic ev, logic [SLOT_ID_W-1:0] es, logic te,
                                          logic signed [TIME_W-1:0] ml);
    result_t r;
    r.expired = ev;
    r.slot    = es;
    r.empty   = te;
    r.ms_left = ml;
    return r;
  endfunction

  // Earliest armed slot, lowest index on a tie; -1 when nothing is armed.
  function automatic int earliest_armed();
    int best;
    best = -1;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (tbl_armed[i] && (best < 0 || tbl_deadline[i] < tbl_deadline[best])) best = i;
    end
    return best;
  endfunction

  // Applies one item to the local table and returns the result it gives.
  function automatic result_t predict_deadlines(logic [REQ_W-1:0] req,
                                                logic [SLOT_ID_W-1:0] slot,
                                                logic [TIME_W-1:0] now);
    result_t       r;
    int            e;
    logic [TIME_W:0] sum;
    longint        diff;
    r = make_result(1'b0, '0, 1'b0, '0);
    case (req)
      REQ_POLL: begin
        clock_ms = now;
        e = earliest_armed();
        // strictly past the deadline
        if (e >= 0 && clock_ms > tbl_deadline[e]) begin
          tbl_armed[e] = 1'b0;
          r.expired = 1'b1;
          r.slot    = e[SLOT_ID_W-1:0];
        end
      end
      REQ_ARM: begin
        sum = {1'b0, clock_ms} + {1'b0, timeout_setting};
        tbl_deadline[slot] = sum[TIME_W] ? '1 : sum[TIME_W-1:0];   // saturate
        tbl_armed[slot]    = 1'b1;
      end
      REQ_CANCEL: tbl_armed[slot] = 1'b0;
      default: ;   // unused code: status only
    endcase
    e = earliest_armed();
    if (e < 0) begin
      r.empty   = 1'b1;
      r.ms_left = -1;
    end else begin
      diff = $signed({32'd0, tbl_deadline[e]}) - $signed({32'd0, clock_ms});
      if (diff > 64'sd2147483647) diff = 64'sd2147483647;
      if (diff < -64'sd2147483648) diff = -64'sd2147483648;
      r.ms_left = diff[TIME_W-1:0];
    end
    return r;
  endfunction

  function automatic void row_cfg(logic [TIME_W-1:0] value);
    stim_row_t row;
    row = '{default: '0};
    row.is_cfg    = 1'b1;
    row.cfg_value = value;
    directed_rows.push_back(row);
  endfunction

  function automatic void row_item(logic [REQ_W-1:0] req, logic [SLOT_ID_W-1:0] slot,
                                   logic [TIME_W-1:0] now);
    stim_row_t row;
    row = '{default: '0};
    row.req  = req;
    row.slot = slot;
    row.now  = now;
    directed_rows.push_back(row);
  endfunction

  function automatic void row_checked(logic [REQ_W-1:0] req, logic [SLOT_ID_W-1:0] slot,
                                      logic [TIME_W-1:0] now, logic ev,
                                      logic [SLOT_ID_W-1:0] es, logic te,
                                      logic signed [TIME_W-1:0] ml);
    stim_row_t row;
    row = '{default: '0};
    row.req   = req;
    row.slot  = slot;
    row.now   = now;
    row.typed = 1'b1;
    row.want  = make_result(ev, es, te, ml);
    directed_rows.push_back(row);
  endfunction

  // Drives one item and holds it until accepted. Valid is left high on
  // acceptance, unless an idle gap follows, so a following item can go back to
  // back; callers that stop sending lower it themselves.
  task automatic send_request(input logic [REQ_W-1:0] req, input logic [SLOT_ID_W-1:0] slot,
                              input logic [TIME_W-1:0] now, input bit typed,
                              input result_t want);
    result_t predicted;
    in_valid <= 1'b1;
    req_type <= req;
    slot_id  <= slot;
    now_ms   <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = predict_deadlines(req, slot, now);
    if (typed) predicted = want;
    pending_results.push_back(predicted);
    // gaps up to past a whole item time so valid rises at every point of the scan
    if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, ITEM_LATENCY + 20)) @(posedge clk);
    end
  endtask

  // timeout_ms is only changed with the block drained.
  task automatic write_timeout(input logic [TIME_W-1:0] value);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en       <= 1'b0;
    timeout_setting = value;
  endtask

  task automatic check_field(input string name, input longint want_v, input longint got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch: expected %0d actual %0d", $time, name, want_v, got_v);
      fail_count++;
    end
  endtask

  // Result side: compare against the oldest prediction, then pick the next
  // out_ready at random.
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none actual %0d %0d %0d %0d", $time,
                 expired_valid, expired_slot, table_empty, ms_to_next);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("expired_valid", want.expired, expired_valid);
        check_field("expired_slot", want.slot, expired_slot);
        check_field("table_empty", want.empty, table_empty);
        check_field("ms_to_next", longint'(want.ms_left), longint'(ms_to_next));
      end
    end
    out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Watchdog: cycles with no item moving on either channel.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [REQ_W-1:0]     req;
    logic [SLOT_ID_W-1:0] slot;
    logic [TIME_W-1:0]    now;
    logic [TIME_W-1:0]    time_cursor;
    logic [TIME_W-1:0]    step_max;
    logic [TIME_W-1:0]    phase_timeout;
    int                   pick;
    result_t              no_want;

    no_want = make_result(1'b0, '0, 1'b0, '0);
    for (int i = 0; i < NUM_SLOTS; i++) begin
      tbl_deadline[i] = '0;
      tbl_armed[i]    = 1'b0;
    end

    // Directed rows. Timeout starts at its reset value of 20000.
    row_checked(REQ_POLL,   6'd0,  32'd0,          0, 6'd0, 1, -1);  // empty after reset
    row_checked(REQ_UNUSED, 6'd63, 32'hFFFF_FFFF,  0, 6'd0, 1, -1);  // unused code
    row_checked(REQ_CANCEL, 6'd5,  32'd0,          0, 6'd0, 1, -1);  // cancel unarmed
    row_checked(REQ_ARM,    6'd63, 32'hFFFF_FFFF,  0, 6'd0, 0, 20000);
    row_checked(REQ_ARM,    6'd0,  32'd0,          0, 6'd0, 0, 20000);  // tie with 63
    row_checked(REQ_POLL,   6'd0,  32'd20000,      0, 6'd0, 0, 0);      // equal: no expiry
    row_checked(REQ_POLL,   6'd0,  32'd20001,      1, 6'd0, 0, -1);     // lower slot first
    row_checked(REQ_POLL,   6'd0,  32'd20001,      1, 6'd63, 1, -1);
    row_checked(REQ_POLL,   6'd0,  32'hFFFF_FFFF,  0, 6'd0, 1, -1);
    row_checked(REQ_ARM,    6'd10, 32'd0,          0, 6'd0, 0, 0);      // deadline saturates
    row_checked(REQ_POLL,   6'd0,  32'd0,          0, 6'd0, 0, 32'sh7FFF_FFFF);
    row_checked(REQ_ARM,    6'd10, 32'd0,          0, 6'd0, 0, 20000);  // refresh re-keys
    row_checked(REQ_CANCEL, 6'd10, 32'd0,          0, 6'd0, 1, -1);
    row_cfg(32'hFFFF_FFFF);
    row_checked(REQ_POLL,   6'd0,  32'd5,          0, 6'd0, 1, -1);
    row_checked(REQ_ARM,    6'd33, 32'd0,          0, 6'd0, 0, 32'sh7FFF_FFFF);
    row_checked(REQ_POLL,   6'd0,  32'hFFFF_FFFF,  0, 6'd0, 0, 0);
    row_cfg(32'd0);   // zero timeout: deadline is the stored time itself
    row_item(REQ_ARM,    6'd1,  32'h5555_5555);
    row_item(REQ_POLL,   6'd0,  32'd0);
    row_item(REQ_ARM,    6'd2,  32'hAAAA_AAAA);
    row_item(REQ_POLL,   6'd0,  32'd1);
    row_cfg(32'd1);
    row_item(REQ_ARM,    6'd41, 32'd0);
    row_item(REQ_ARM,    6'd40, 32'd0);
    // slot 40 goes, slot 41 is far past: ms_to_next pinned at the minimum
    row_checked(REQ_POLL,   6'd0,  32'hFFFF_FFFF,  1, 6'd40, 0, 32'sh8000_0000);
    row_item(REQ_POLL,   6'd0,  32'hFFFF_FFFF);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // the block runs its clearing pass first; send_request waits on in_ready
    foreach (directed_rows[k]) begin
      if (directed_rows[k].is_cfg) begin
        write_timeout(directed_rows[k].cfg_value);
      end else begin
        send_request(directed_rows[k].req, directed_rows[k].slot, directed_rows[k].now,
                     directed_rows[k].typed, directed_rows[k].want);
      end
    end

    // Random phases. Polls mostly walk time forward in steps on the scale of
    // the timeout so slots expire; a few jump anywhere, backwards included.
    time_cursor = clock_ms;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       phase_timeout = $urandom_range(50, 3000);
        1:       phase_timeout = 32'd1;
        2:       phase_timeout = 32'hFFFF_FFFF;
        3:       phase_timeout = $urandom;
        4:       phase_timeout = $urandom_range(200, 20000);
        default: phase_timeout = TIMEOUT_RST;
      endcase
      write_timeout(phase_timeout);
      step_max = (timeout_setting > 32'd50000) ? 32'd100000 : timeout_setting * 2 + 2;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        no_idle = (p == 3 && n < 150);   // long stretch at full rate
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          req = REQ_POLL;
        end else if (pick < 80) begin
          req = REQ_ARM;
        end else if (pick < 95) begin
          req = REQ_CANCEL;
        end else begin
          req = REQ_UNUSED;
        end
        // half the traffic on a few slots: refreshes, ties, re-arms
        slot = ($urandom_range(0, 1) == 0) ? SLOT_ID_W'($urandom_range(0, 7))
                                           : SLOT_ID_W'($urandom_range(0, 63));
        now  = $urandom;
        if (req == REQ_POLL) begin
          if ($urandom_range(0, 99) < 92) begin
            time_cursor = time_cursor + $urandom_range(0, step_max);
            now = time_cursor;
          end else begin
            time_cursor = now;
          end
        end
        send_request(req, slot, now, 1'b0, no_want);
      end
    end
    no_idle = 1'b0;

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (ITEM_LATENCY + 13) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
